// ===== rtl/core/sjis_pkg.sv =====
// Shared types, mode codes and the half-width kana table of the Shift-JIS widener.
package sjis_pkg;

   localparam int ByteW = 8;

   localparam logic [ByteW-1:0] LeadLo1 = 8'h81;
   localparam logic [ByteW-1:0] LeadHi1 = 8'h9f;
   localparam logic [ByteW-1:0] LeadLo2 = 8'he0;
   localparam logic [ByteW-1:0] LeadHi2 = 8'hef;
   localparam logic [ByteW-1:0] EscByte = 8'h1b;
   localparam logic [ByteW-1:0] NulByte = 8'h00;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'b001,
      MODE_TRAIL  = 3'b010,
      MODE_ESC    = 3'b100
   } mode_type;

   typedef struct packed {
      logic             hit;
      logic [ByteW-1:0] hi;
      logic [ByteW-1:0] lo;
   } kana_type;

   typedef struct packed {
      logic             valid;
      logic [ByteW-1:0] data;
      kana_type         kana;
   } item_type;

   function automatic kana_type kana_lookup(input logic [ByteW-1:0] b);
      kana_type r;
      r.hit = 1'b1;
      r.hi  = 8'h82;
      r.lo  = 8'h00;
      case (b)
         8'ha0: begin r.hi = 8'h81; r.lo = 8'h40; end
         8'h21: begin r.hi = 8'h81; r.lo = 8'h49; end
         8'h3f: begin r.hi = 8'h81; r.lo = 8'h48; end
         8'ha5: begin r.hi = 8'h81; r.lo = 8'h63; end
         8'ha1: begin r.hi = 8'h81; r.lo = 8'h42; end
         8'ha2: begin r.hi = 8'h81; r.lo = 8'h75; end
         8'ha3: begin r.hi = 8'h81; r.lo = 8'h76; end
         8'ha4: begin r.hi = 8'h81; r.lo = 8'h41; end
         8'ha6: r.lo = 8'hf0;
         8'ha7: r.lo = 8'h9f;
         8'ha8: r.lo = 8'ha1;
         8'ha9: r.lo = 8'ha3;
         8'haa: r.lo = 8'ha5;
         8'hab: r.lo = 8'ha7;
         8'hac: r.lo = 8'he1;
         8'had: r.lo = 8'he3;
         8'hae: r.lo = 8'he5;
         8'haf: r.lo = 8'hc1;
         8'hb0: begin r.hi = 8'h81; r.lo = 8'h5b; end
         8'hb1: r.lo = 8'ha0;
         8'hb2: r.lo = 8'ha2;
         8'hb3: r.lo = 8'ha4;
         8'hb4: r.lo = 8'ha6;
         8'hb5: r.lo = 8'ha8;
         8'hb6: r.lo = 8'ha9;
         8'hb7: r.lo = 8'hab;
         8'hb8: r.lo = 8'had;
         8'hb9: r.lo = 8'haf;
         8'hba: r.lo = 8'hb1;
         8'hbb: r.lo = 8'hb3;
         8'hbc: r.lo = 8'hb5;
         8'hbd: r.lo = 8'hb7;
         8'hbe: r.lo = 8'hb9;
         8'hbf: r.lo = 8'hbb;
         8'hc0: r.lo = 8'hbd;
         8'hc1: r.lo = 8'hbf;
         8'hc2: r.lo = 8'hc2;
         8'hc3: r.lo = 8'hc4;
         8'hc4: r.lo = 8'hc6;
         8'hc5: r.lo = 8'hc8;
         8'hc6: r.lo = 8'hc9;
         8'hc7: r.lo = 8'hca;
         8'hc8: r.lo = 8'hcb;
         8'hc9: r.lo = 8'hcc;
         8'hca: r.lo = 8'hcd;
         8'hcb: r.lo = 8'hd0;
         8'hcc: r.lo = 8'hd3;
         8'hcd: r.lo = 8'hd6;
         8'hce: r.lo = 8'hd9;
         8'hcf: r.lo = 8'hdc;
         8'hd0: r.lo = 8'hdd;
         8'hd1: r.lo = 8'hde;
         8'hd2: r.lo = 8'hdf;
         8'hd3: r.lo = 8'he0;
         8'hd4: r.lo = 8'he2;
         8'hd5: r.lo = 8'he4;
         8'hd6: r.lo = 8'he6;
         8'hd7: r.lo = 8'he7;
         8'hd8: r.lo = 8'he8;
         8'hd9: r.lo = 8'he9;
         8'hda: r.lo = 8'hea;
         8'hdb: r.lo = 8'heb;
         8'hdc: r.lo = 8'hed;
         8'hdd: r.lo = 8'hf1;
         default: begin
            r.hit = 1'b0;
            r.hi  = 8'h00;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/sjis_fetch.sv =====
// Input stage: takes a byte transfer and registers it with its kana table lookup.
module sjis_fetch (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [sjis_pkg::ByteW-1:0]   req_tdata,   // [7:0] in_byte
   input  logic                         consume,
   output sjis_pkg::item_type           item
);
   import sjis_pkg::*;

   logic             valid_ff, valid_in;
   logic [ByteW-1:0] data_ff;
   kana_type         kana_ff;
   logic             accept;

   assign req_tready = !valid_ff || consume;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (consume) valid_in = 1'b0;
      if (accept)  valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // table read is registered together with the byte
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_tdata;
         kana_ff <= kana_lookup(req_tdata);
      end
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;
   assign item.kana  = kana_ff;

endmodule

// ===== rtl/core/sjis_emit.sv =====
// Decode stage: tracks the byte mode and drives the result register.
module sjis_emit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         convert_enable,
   input  sjis_pkg::item_type           item,
   output logic                         consume,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [sjis_pkg::ByteW-1:0]   rsp_tdata,   // [7:0] out_byte
   output logic                         rsp_tlast,   // last_of_run
   output logic                         rsp_tuser    // [0] end_of_string
);
   import sjis_pkg::*;

   mode_type         mode_ff, mode_in;
   logic             out_valid_ff, out_valid_in;
   logic [ByteW-1:0] out_data_ff, out_data_in;
   logic             out_last_ff, out_last_in;
   logic             out_end_ff, out_end_in;
   logic             lo_valid_ff, lo_valid_in;
   logic [ByteW-1:0] lo_data_ff, lo_data_in;
   logic             slot_free;
   logic             is_lead;

   assign slot_free = !out_valid_ff || rsp_tready;
   assign is_lead   = ((item.data >= LeadLo1) && (item.data <= LeadHi1)) ||
                      ((item.data >= LeadLo2) && (item.data <= LeadHi2));
   assign consume   = slot_free && !lo_valid_ff && item.valid;

   always_comb begin
      mode_in      = mode_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_end_in   = out_end_ff;
      lo_valid_in  = lo_valid_ff;
      lo_data_in   = lo_data_ff;
      if (slot_free && lo_valid_ff) begin
         // second byte of a widened kana
         out_valid_in = 1'b1;
         out_data_in  = lo_data_ff;
         out_last_in  = 1'b1;
         out_end_in   = 1'b0;
         lo_valid_in  = 1'b0;
      end else if (consume) begin
         out_valid_in = 1'b1;
         out_data_in  = item.data;
         out_last_in  = 1'b1;
         out_end_in   = 1'b0;
         mode_in      = MODE_NORMAL;
         if (item.data == NulByte) begin
            out_end_in = 1'b1;
         end else if (!convert_enable || (mode_ff != MODE_NORMAL)) begin
            // pass trail or escaped byte unchanged
         end else if (is_lead) begin
            mode_in = MODE_TRAIL;
         end else if (item.data == EscByte) begin
            // drop the escape itself
            out_valid_in = 1'b0;
            mode_in      = MODE_ESC;
         end else if (item.kana.hit) begin
            out_data_in = item.kana.hi;
            out_last_in = 1'b0;
            lo_valid_in = 1'b1;
            lo_data_in  = item.kana.lo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         out_valid_ff <= 1'b0;
         lo_valid_ff  <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         out_valid_ff <= out_valid_in;
         lo_valid_ff  <= lo_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_end_ff  <= out_end_in;
      lo_data_ff  <= lo_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_end_ff;

endmodule

// ===== rtl/core/sjis_halfwidth_kana_widener_unit.sv =====
// Shift-JIS half-width kana widener: top level with the enable register.
// Path: the input byte is registered in the fetch stage, then in the result register.
// Throughput: one input byte per cycle while the result channel is ready; a widened
// kana puts two bytes on the result channel, and input waits while the second is pending.
// Reset: synchronous, clears the byte mode, the enable register and all valids.
module sjis_halfwidth_kana_widener_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [sjis_pkg::ByteW-1:0]   req_tdata,   // [7:0] in_byte
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [sjis_pkg::ByteW-1:0]   rsp_tdata,   // [7:0] out_byte
   output logic                         rsp_tlast,   // last_of_run
   output logic                         rsp_tuser,   // [0] end_of_string
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_wdata    // convert_enable
);
   import sjis_pkg::*;

   logic     enable_ff;
   logic     consume;
   item_type item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (csr_valid) begin
         enable_ff <= csr_wdata;
      end
   end

   sjis_fetch u_fetch (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .consume    (consume),
      .item       (item)
   );

   sjis_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .convert_enable (enable_ff),
      .item           (item),
      .consume        (consume),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser)
   );

endmodule

// ===== bench/sjis_halfwidth_kana_widener_unit_tb.sv =====
// Self-checking testbench for the Shift-JIS half-width kana widener.
`timescale 1ns / 100ps

module sjis_halfwidth_kana_widener_unit_tb;
   import sjis_pkg::*;

   localparam logic [ByteW-1:0] KanaFirst = 8'ha0;
   localparam logic [ByteW-1:0] KanaLast  = 8'hdd;
   localparam logic [ByteW-1:0] BangByte  = 8'h21;
   localparam logic [ByteW-1:0] QueryByte = 8'h3f;
   localparam int WatchdogLimit = 2000;
   localparam int SettleCycles  = 4;

   // Predicts the widened byte stream and checks the result channel against it.
   class widen_scoreboard;
      typedef struct packed {
         logic [ByteW-1:0] data;
         logic             last;
         logic             eos;
      } wide_byte_type;

      wide_byte_type    expected_bytes[$];
      logic [23:0]      kana_map[64];   // {half-width byte, full-width hi, full-width lo}
      bit               convert_on;
      mode_type         shift_mode;
      int               errors;

      function new();
         kana_map = '{
            24'ha08140, 24'h218149, 24'h3f8148, 24'ha58163,
            24'ha18142, 24'ha28175, 24'ha38176, 24'ha48141,
            24'ha682f0, 24'ha7829f, 24'ha882a1, 24'ha982a3,
            24'haa82a5, 24'hab82a7, 24'hac82e1, 24'had82e3,
            24'hae82e5, 24'haf82c1, 24'hb0815b, 24'hb182a0,
            24'hb282a2, 24'hb382a4, 24'hb482a6, 24'hb582a8,
            24'hb682a9, 24'hb782ab, 24'hb882ad, 24'hb982af,
            24'hba82b1, 24'hbb82b3, 24'hbc82b5, 24'hbd82b7,
            24'hbe82b9, 24'hbf82bb, 24'hc082bd, 24'hc182bf,
            24'hc282c2, 24'hc382c4, 24'hc482c6, 24'hc582c8,
            24'hc682c9, 24'hc782ca, 24'hc882cb, 24'hc982cc,
            24'hca82cd, 24'hcb82d0, 24'hcc82d3, 24'hcd82d6,
            24'hce82d9, 24'hcf82dc, 24'hd082dd, 24'hd182de,
            24'hd282df, 24'hd382e0, 24'hd482e2, 24'hd582e4,
            24'hd682e6, 24'hd782e7, 24'hd882e8, 24'hd982e9,
            24'hda82ea, 24'hdb82eb, 24'hdc82ed, 24'hdd82f1
         };
         convert_on = 1'b0;
         shift_mode = MODE_NORMAL;
         errors     = 0;
      endfunction

      function void set_convert(bit v);
         convert_on = v;
      endfunction

      function void push_byte(logic [ByteW-1:0] d, logic last, logic eos);
         wide_byte_type w;
         w.data = d;
         w.last = last;
         w.eos  = eos;
         expected_bytes.push_back(w);
      endfunction

      // Work out the bytes one accepted input byte produces.
      function void predict_bytes(logic [ByteW-1:0] b);
         int hit;
         hit = -1;
         if (b == NulByte) begin
            shift_mode = MODE_NORMAL;
            push_byte(NulByte, 1'b1, 1'b1);
         end else if (!convert_on || shift_mode != MODE_NORMAL) begin
            // trail or escaped byte, or conversion off: pass it as it is
            shift_mode = MODE_NORMAL;
            push_byte(b, 1'b1, 1'b0);
         end else if ((b >= LeadLo1 && b <= LeadHi1) || (b >= LeadLo2 && b <= LeadHi2)) begin
            shift_mode = MODE_TRAIL;
            push_byte(b, 1'b1, 1'b0);
         end else if (b == EscByte) begin
            shift_mode = MODE_ESC;
         end else begin
            for (int i = 0; i < 64; i++)
               if (kana_map[i][23:16] == b) hit = i;
            if (hit >= 0) begin
               push_byte(kana_map[hit][15:8], 1'b0, 1'b0);
               push_byte(kana_map[hit][7:0], 1'b1, 1'b0);
            end else begin
               push_byte(b, 1'b1, 1'b0);
            end
         end
      endfunction

      function void check_byte(logic [ByteW-1:0] d, logic last, logic eos);
         wide_byte_type want;
         if (expected_bytes.size() == 0) begin
            $error("unexpected result transfer: out_byte %02h", d);
            errors++;
            return;
         end
         want = expected_bytes.pop_front();
         if (d !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, d);
            errors++;
         end
         if (last !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, last);
            errors++;
         end
         if (eos !== want.eos) begin
            $error("end_of_string: expected %0b, got %0b", want.eos, eos);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [ByteW-1:0] req_tdata  = '0;   // [7:0] in_byte
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [ByteW-1:0] rsp_tdata;         // [7:0] out_byte
   logic             rsp_tlast;
   logic             rsp_tuser;         // [0] end_of_string
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic             csr_wdata  = 1'b0;

   widen_scoreboard  sb;
   bit               quiet = 1'b0;
   int               sent_count = 0;
   int               stall_left = 0;
   int               idle_cycles = 0;

   logic [ByteW-1:0] off_bytes[$] = '{8'ha5, 8'h1b, 8'h81, 8'h00};
   logic [ByteW-1:0] corner_bytes[$] = '{
      8'h00, 8'hff, 8'ha0, 8'hdd, 8'h21, 8'h3f, 8'ha5, 8'hb0, 8'h81, 8'h40,
      8'h9f, 8'ha5, 8'he0, 8'h00, 8'hef, 8'h7f, 8'h1b, 8'h00, 8'h1b, 8'hb1,
      8'h1b, 8'h1b, 8'h80, 8'hde, 8'hf0
   };

   sjis_halfwidth_kana_widener_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: check each transfer, stall in short random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_byte(rsp_tdata, rsp_tlast, rsp_tuser);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 4) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // End the run when no channel has moved a transfer for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_byte(input logic [ByteW-1:0] b);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sb.predict_bytes(b);
      sent_count++;
   endtask

   // Wait for every expected byte, then let an escape still in flight settle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_convert(input bit v);
      drain_results();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_convert(v);
   endtask

   // A well-formed string of random tokens, now and then without its terminator.
   task automatic send_string();
      int               len;
      logic [ByteW-1:0] b;
      len = $urandom_range(1, 10);
      repeat (len) begin
         case ($urandom_range(0, 9))
            0, 1, 2: send_byte(8'($urandom_range(KanaFirst, KanaLast)));
            3: send_byte($urandom_range(0, 1) ? BangByte : QueryByte);
            4, 5: begin
               if ($urandom_range(0, 1)) b = 8'($urandom_range(LeadLo1, LeadHi1));
               else b = 8'($urandom_range(LeadLo2, LeadHi2));
               send_byte(b);
               // trail byte; a zero here ends the string early
               send_byte(($urandom_range(0, 11) == 0) ? NulByte : 8'($urandom_range(1, 255)));
            end
            6: begin
               send_byte(EscByte);
               send_byte(($urandom_range(0, 11) == 0) ? NulByte : 8'($urandom_range(1, 255)));
            end
            7: send_byte(8'($urandom_range(8'h20, 8'h7e)));
            default: send_byte(8'($urandom_range(1, 255)));
         endcase
      end
      if ($urandom_range(0, 5) != 0)
         send_byte(NulByte);
   endtask

   task automatic send_random(input int target);
      while (sent_count < target) begin
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
         else
            send_string();
      end
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // conversion is off out of reset
      foreach (off_bytes[i]) send_byte(off_bytes[i]);

      write_convert(1'b1);
      foreach (corner_bytes[i]) send_byte(corner_bytes[i]);
      send_random(480);

      write_convert(1'b0);
      send_random(680);

      write_convert(1'b1);
      quiet = 1'b1;
      send_random(950);

      drain_results();
      if (sb.errors == 0 && sb.expected_bytes.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/sjis_pkg.sv
rtl/core/sjis_fetch.sv
rtl/core/sjis_emit.sv
rtl/core/sjis_halfwidth_kana_widener_unit.sv
bench/sjis_halfwidth_kana_widener_unit_tb.sv
